FILE: sv/bresenham_line_rasterizer_core_defines.svh
// ----------------------------------------------------------------------------
// Bresenham line rasterizer: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_DEFINES_SVH

// property holds at every edge out of reset
`define BLR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed: %m");

// antecedent at one edge implies consequent at the next
`define BLR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

FILE: sv/blr_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer: package
// Item types, job record, state encodings and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

  localparam int unsigned COORD_W     = 8;
  localparam int unsigned RES_W       = 9;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned MAX_RES_DEF = 256;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [RES_W-1:0] RES_RESET = 9'd256;

  // command codes
  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_RES = 1'b0,
    CFG_Y_RES = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic               command;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] read_x;
    logic [COORD_W-1:0] read_y;
  } in_t;

  typedef struct packed {
    logic line_accepted;
    logic pixel_mark;
  } res_t;

  // job kinds handed from front to back
  typedef enum logic [1:0] {
    JOB_READ   = 2'd0,
    JOB_DRAW   = 2'd1,
    JOB_REJECT = 2'd2
  } job_e;

  // classified item: walk start, major length, minor delta, direction
  typedef struct packed {
    job_e               kind;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] len;
    logic [COORD_W-1:0] dmn;
    logic               major_x;
    logic               step_neg;
    logic               vert;
  } job_t;

  // back-end status seen by the front end
  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [2:0] {
    BK_CLEAR = 3'd0,
    BK_IDLE  = 3'd1,
    BK_WALK  = 3'd2,
    BK_READ  = 3'd3,
    BK_REPLY = 3'd4
  } back_state_e;

endpackage

`default_nettype wire

FILE: sv/blr_fifo.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer: small queue
// Register-based FIFO that decouples two sides of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = blr_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output item_t      data_o,
  output logic       empty_o
);
  import blr_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         store_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/blr_front.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer: front end
// Holds resolution registers, accepts items, runs the on-screen test and
// works out octant, walk start, lengths and direction for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module blr_front #(
  parameter int unsigned MAX_RESOLUTION = blr_pkg::MAX_RES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [blr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [blr_pkg::RES_W-1:0]      cfg_data_i,
  input  wire logic                           push_i,
  input  wire blr_pkg::in_t                   item_i,
  output logic                                full_o,
  input  wire blr_pkg::back_stat_t            stat_i,
  input  wire logic                           job_full_i,
  output logic                                job_push_o,
  output blr_pkg::job_t                       job_o
);
  import blr_pkg::*;

  logic [RES_W-1:0] xres_q, yres_q;

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W-1:0]      adx, ady;
  logic                    xmaj, swap, ok;
  logic [COORD_W-1:0]      sx, sy, fx, fy;

  function automatic logic on_scr(input logic [COORD_W-1:0] c,
                                  input logic [RES_W-1:0]   res);
    return (c != '0) && ({1'b0, c} < res) && (32'(c) < MAX_RESOLUTION);
  endfunction

  // resolution registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xres_q <= RES_RESET;
      yres_q <= RES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_X_RES: xres_q <= cfg_data_i;
        CFG_Y_RES: yres_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: stall while the store is swept or the job queue is full
  assign full_o     = job_full_i || stat_i.clearing;
  assign job_push_o = push_i && !full_o;

  // classification and octant setup
  always_comb begin
    dx   = $signed({1'b0, item_i.end_x}) - $signed({1'b0, item_i.start_x});
    dy   = $signed({1'b0, item_i.end_y}) - $signed({1'b0, item_i.start_y});
    adx  = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
    ady  = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
    xmaj = (ady <= adx);
    // walk from the smaller end of the major axis
    swap = xmaj ? dx[COORD_W] : dy[COORD_W];
    sx   = swap ? item_i.end_x   : item_i.start_x;
    sy   = swap ? item_i.end_y   : item_i.start_y;
    fx   = swap ? item_i.start_x : item_i.end_x;
    fy   = swap ? item_i.start_y : item_i.end_y;
    ok   = on_scr(item_i.start_x, xres_q) && on_scr(item_i.start_y, yres_q) &&
           on_scr(item_i.end_x, xres_q)   && on_scr(item_i.end_y, yres_q);

    job_o.x0       = sx;
    job_o.y0       = sy;
    job_o.len      = xmaj ? adx : ady;
    job_o.dmn      = xmaj ? ady : adx;
    job_o.major_x  = xmaj;
    job_o.step_neg = xmaj ? (fy < sy) : (fx < sx);
    job_o.vert     = (dx == '0);
    job_o.kind     = ok ? JOB_DRAW : JOB_REJECT;
    if (item_i.command == CMD_READ) begin
      job_o.kind = JOB_READ;
      job_o.x0   = item_i.read_x;
      job_o.y0   = item_i.read_y;
    end
  end

endmodule

`default_nettype wire

FILE: sv/blr_back.sv
// ----------------------------------------------------------------------------
// Bresenham line rasterizer: back end
// Owns the one-bit frame store, sweeps it clear after reset, walks lines
// one pixel per cycle and serves pixel reads.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_rasterizer_core_defines.svh"

module blr_back #(
  parameter int unsigned MAX_RESOLUTION = blr_pkg::MAX_RES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire blr_pkg::job_t  job_i,
  input  wire logic           job_empty_i,
  output logic                job_pop_o,
  output blr_pkg::back_stat_t stat_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output blr_pkg::res_t       res_o
);
  import blr_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_RESOLUTION);
  localparam int unsigned MAW   = 2 * AW;
  localparam int unsigned DEPTH = 1 << MAW;
  localparam int unsigned EW    = COORD_W + 2;
  localparam int unsigned CNT_W = COORD_W + 1;

  back_state_e state_q, state_d;

  // frame store
  logic           frame_q [DEPTH];
  logic           wr_en, wr_bit, rd_en;
  logic [MAW-1:0] wr_addr, rd_addr;
  logic           rd_data_q;
  logic           rd_ok_q, rd_ok_d;
  logic [MAW-1:0] clr_q, clr_d;

  // walker
  logic [COORD_W-1:0]   maj_q, maj_d, mnr_q, mnr_d;
  logic [COORD_W-1:0]   len_q, len_d, dmn_q, dmn_d;
  logic signed [EW-1:0] err_q, err_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 major_x_q, major_x_d, step_neg_q, step_neg_d;

  logic [COORD_W-1:0]   px, py;
  logic signed [EW:0]   esum;
  logic                 take;

  assign stat_o.clearing = (state_q == BK_CLEAR);

  // one Bresenham step from the current walker state
  always_comb begin
    px   = major_x_q ? maj_q : mnr_q;
    py   = major_x_q ? mnr_q : maj_q;
    esum = $signed({err_q[EW-1], err_q}) + $signed({2'b00, 1'b0, dmn_q});
    take = $signed({esum, 1'b0}) < $signed({4'b0000, len_q});
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    maj_d      = maj_q;
    mnr_d      = mnr_q;
    len_d      = len_q;
    dmn_d      = dmn_q;
    err_d      = err_q;
    cnt_d      = cnt_q;
    major_x_d  = major_x_q;
    step_neg_d = step_neg_q;
    rd_ok_d    = rd_ok_q;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    wr_en      = 1'b0;
    wr_bit     = 1'b0;
    wr_addr    = clr_q;
    rd_en      = 1'b0;
    rd_addr    = {AW'(job_i.y0), AW'(job_i.x0)};

    unique case (state_q)
      BK_CLEAR: begin
        wr_en = 1'b1;
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!job_empty_i) begin
          unique case (job_i.kind)
            JOB_READ: begin
              rd_en     = 1'b1;
              rd_ok_d   = (32'(job_i.x0) < MAX_RESOLUTION) &&
                          (32'(job_i.y0) < MAX_RESOLUTION);
              job_pop_o = 1'b1;
              state_d   = BK_READ;
            end
            JOB_DRAW: begin
              maj_d      = job_i.major_x ? job_i.x0 : job_i.y0;
              mnr_d      = job_i.major_x ? job_i.y0 : job_i.x0;
              len_d      = job_i.len;
              dmn_d      = job_i.dmn;
              err_d      = '0;
              cnt_d      = {1'b0, job_i.len} + CNT_W'(job_i.vert);
              major_x_d  = job_i.major_x;
              step_neg_d = job_i.step_neg;
              job_pop_o  = 1'b1;
              state_d    = BK_WALK;
            end
            JOB_REJECT: begin
              if (!res_full_i) begin
                res_push_o = 1'b1;
                job_pop_o  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      BK_WALK: begin
        // mark the current pixel where it falls inside the store
        wr_en   = (32'(px) < MAX_RESOLUTION) && (32'(py) < MAX_RESOLUTION);
        wr_bit  = 1'b1;
        wr_addr = {AW'(py), AW'(px)};
        maj_d   = maj_q + 1'b1;
        if (take) begin
          err_d = EW'(esum);
        end else begin
          err_d = EW'(esum - $signed({3'b000, len_q}));
          mnr_d = step_neg_q ? mnr_q - 1'b1 : mnr_q + 1'b1;
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = BK_REPLY;
        end
      end
      BK_READ: begin
        if (!res_full_i) begin
          res_push_o       = 1'b1;
          res_o.pixel_mark = rd_data_q && rd_ok_q;
          state_d          = BK_IDLE;
        end
      end
      BK_REPLY: begin
        if (!res_full_i) begin
          res_push_o          = 1'b1;
          res_o.line_accepted = 1'b1;
          state_d             = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
    end
  end

  // walker and read payload registers
  always_ff @(posedge clk_i) begin
    maj_q      <= maj_d;
    mnr_q      <= mnr_d;
    len_q      <= len_d;
    dmn_q      <= dmn_d;
    err_q      <= err_d;
    major_x_q  <= major_x_d;
    step_neg_q <= step_neg_d;
    rd_ok_q    <= rd_ok_d;
  end

  // frame store write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_q[wr_addr] <= wr_bit;
    end
  end

  // frame store read port, registered data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= frame_q[rd_addr];
    end
  end

  `BLR_ASSERT(a_pop_in_idle, !job_pop_o || (state_q == BK_IDLE && !job_empty_i))
  `BLR_ASSERT(a_push_has_room, !res_push_o || !res_full_i)
  `BLR_ASSERT(a_wr_in_walk_clear, !wr_en || state_q == BK_WALK || state_q == BK_CLEAR)
  `BLR_ASSERT(a_walk_cnt_live, state_q != BK_WALK || cnt_q != '0)
  `BLR_ASSERT_NXT(a_clear_once, state_q != BK_CLEAR, state_q != BK_CLEAR)

endmodule

`default_nettype wire

FILE: sv/bresenham_line_rasterizer_core.sv
// Flow: an accepted item passes the job queue, the back end and the result queue
// before its result can be popped; a walk takes L steps, L the major-axis length
// (+1 vertical). Throughput: set by the one-pixel-per-cycle walker and the single
// frame-store write port; the back end takes a new job only in its idle state.
// Reset: all 4**clog2(MAX_RESOLUTION) frame-store bits (65536 at 256) are swept
// clear with full high; configuration writes are taken during the sweep.
// ----------------------------------------------------------------------------
// Bresenham line rasterizer core
// Front end classifies items into a short job queue; back end walks lines
// into a one-bit frame store; results leave through a small result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer_core #(
  parameter int unsigned MAX_RESOLUTION = blr_pkg::MAX_RES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [blr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [blr_pkg::RES_W-1:0]     cfg_data_i,
  input  wire logic                          push,
  input  wire blr_pkg::in_t                  in_item_i,
  output logic                               full,
  output logic                               empty,
  input  wire logic                          pop,
  output blr_pkg::res_t                      res_item_o
);
  import blr_pkg::*;

  job_t       job_in, job_out;
  logic       job_push, job_full, job_empty, job_pop;
  back_stat_t stat;
  res_t       res_in;
  logic       res_push, res_full;

  blr_front #(
    .MAX_RESOLUTION(MAX_RESOLUTION)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_o     (full),
    .stat_i     (stat),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  // job queue between front and back
  blr_fifo #(
    .item_t(job_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  blr_back #(
    .MAX_RESOLUTION(MAX_RESOLUTION)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .stat_o      (stat),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // result queue toward the consumer
  blr_fifo #(
    .item_t(res_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_item_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire
